/* src/csfw_pkg.sv */
// Shared types and constants of the counting semaphore with FIFO wait ring.
package csfw_pkg;

  // Fixed field widths of the request and response transactions
  localparam int REQ_TYPE_W = 3;
  localparam int ID_W       = 4;
  localparam int STATUS_W   = 4;
  localparam int COUNT_W    = 16;

  // Configuration port
  localparam int CFG_W      = 16;
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 3;
  localparam logic REG_INITIAL_COUNT = 1'b0;

  // Defaults of the top-level parameters
  localparam int DEF_MAX_REQUESTERS = 16;
  localparam int DEF_COUNT_BITS     = 16;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ACQUIRE     = 3'd0,
    REQ_TRY_ACQUIRE = 3'd1,
    REQ_RELEASE     = 3'd2,
    REQ_CANCEL      = 3'd3,
    REQ_QUERY       = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_QUEUED      = 4'd1,
    ST_RAISED      = 4'd2,
    ST_HANDED      = 4'd3,
    ST_CANCELLED   = 4'd4,
    ST_NOT_WAITING = 4'd5,
    ST_BUSY        = 4'd6,
    ST_ALREADY     = 4'd7,
    ST_SATURATED   = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LINK = 3'b100
  } state_t;

endpackage

/* src/csfw_links.sv */
// Link store of the wait ring: next and prev pointers, one entry per requester.
module csfw_links #(
  parameter int MAX_REQUESTERS = csfw_pkg::DEF_MAX_REQUESTERS,
  localparam int IdxW = $clog2(MAX_REQUESTERS)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [IdxW-1:0] rd_addr,
  output logic [IdxW-1:0] nx_rd,
  output logic [IdxW-1:0] pv_rd,
  input  logic            nx_we,
  input  logic [IdxW-1:0] nx_wa,
  input  logic [IdxW-1:0] nx_wd,
  input  logic            pv_we,
  input  logic [IdxW-1:0] pv_wa,
  input  logic [IdxW-1:0] pv_wd
);

  logic [IdxW-1:0] link_next [MAX_REQUESTERS];
  logic [IdxW-1:0] link_prev [MAX_REQUESTERS];

  // Write the next pointers
  always_ff @(posedge clk) begin
    if (nx_we) begin
      link_next[nx_wa] <= nx_wd;
    end
  end

  // Write the prev pointers
  always_ff @(posedge clk) begin
    if (pv_we) begin
      link_prev[pv_wa] <= pv_wd;
    end
  end

  // Read both pointers of one entry, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      nx_rd <= link_next[rd_addr];
      pv_rd <= link_prev[rd_addr];
    end
  end

endmodule

/* src/counting_semaphore_fifo_waiters_core.sv */
// Top level of the counting semaphore with a FIFO wait ring of requesters.
//
// Request channel: req_valid/req_stall carry req_type and requester_id.
// Response channel: rsp_valid/rsp_stall carry status, woken_valid, woken_id,
// count_now and still_waiting; one response transaction per request.
// A request is taken in the idle state, which also reads the link entry of the
// named requester (or of the ring head for a release). The execution state
// then updates the count, the waiting flags and the links and loads the
// response register. No new request is taken before the last one has left
// execution and the link state; an acquire that joins a non-empty ring also
// passes through the link state, as the link store has one write port per
// pointer array and that enqueue rewrites two entries of each.
// req_stall is high while a request is in flight; the next request is taken
// while an earlier response still waits. If rsp_stall holds the response
// register, the following request waits in execution until it frees.
// Reset (rst, synchronous) clears the count and initial_count to zero and
// empties the ring; no clearing pass is needed. Writing initial_count over
// the APB port loads the count and empties the ring; write only when idle.
module counting_semaphore_fifo_waiters_core #(
  parameter int MAX_REQUESTERS = csfw_pkg::DEF_MAX_REQUESTERS,
  parameter int COUNT_BITS     = csfw_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [csfw_pkg::REQ_TYPE_W-1:0]   req_type,
  input  logic [csfw_pkg::ID_W-1:0]         requester_id,
  // response channel
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [csfw_pkg::STATUS_W-1:0]     status,
  output logic                              woken_valid,
  output logic [csfw_pkg::ID_W-1:0]         woken_id,
  output logic [csfw_pkg::COUNT_W-1:0]      count_now,
  output logic                              still_waiting,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csfw_pkg::PADDR_W-1:0]      paddr,
  input  logic [csfw_pkg::PDATA_W-1:0]      pwdata,
  output logic [csfw_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int IdxW  = $clog2(MAX_REQUESTERS);
  localparam int WideW = (IdxW > csfw_pkg::ID_W) ? IdxW : csfw_pkg::ID_W;
  localparam int CNT_CFG_W = csfw_pkg::CFG_W;

  // Control state
  csfw_pkg::state_t       state;
  logic [COUNT_BITS-1:0]  sem_count;
  logic [CNT_CFG_W-1:0]   initial_count;
  logic [MAX_REQUESTERS-1:0] waiting_flag;
  logic [IdxW-1:0]        ring_head;
  logic [IdxW-1:0]        ring_tail;
  logic                   ring_nonempty;
  logic [IdxW-1:0]        pend_tail;

  // Latched request
  csfw_pkg::req_t         req_q;
  logic [IdxW-1:0]        idx_q;
  logic                   in_range_q;

  // Request decode
  logic [WideW-1:0]       id_wide;
  logic [IdxW-1:0]        id_idx;
  logic                   id_in_range;
  logic                   req_fire;
  logic                   exec_fire;
  logic                   cfg_write;

  // Link store
  logic [IdxW-1:0]        rd_addr;
  logic [IdxW-1:0]        nx_rd;
  logic [IdxW-1:0]        pv_rd;
  logic                   nx_we;
  logic [IdxW-1:0]        nx_wa;
  logic [IdxW-1:0]        nx_wd;
  logic                   pv_we;
  logic [IdxW-1:0]        pv_wa;
  logic [IdxW-1:0]        pv_wd;

  // Execute results
  logic                   waits;
  csfw_pkg::status_t      st_next;
  logic                   wv_next;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   do_enq;
  logic                   do_unl;
  logic [IdxW-1:0]        unl_node;
  logic                   unl_last;
  logic                   sw_next;

  assign id_wide     = WideW'(requester_id);
  assign id_idx      = id_wide[IdxW-1:0];
  assign id_in_range = 32'(requester_id) < 32'(MAX_REQUESTERS);

  assign req_stall = (state != csfw_pkg::S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign exec_fire = (state == csfw_pkg::S_EXEC) && (!rsp_valid || !rsp_stall);
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == csfw_pkg::REG_INITIAL_COUNT);

  // APB read back and ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == csfw_pkg::REG_INITIAL_COUNT) ?
                  csfw_pkg::PDATA_W'(initial_count) : '0;

  // Release reads the head entry, every other request the named entry
  assign rd_addr = (csfw_pkg::req_t'(req_type) == csfw_pkg::REQ_RELEASE) ?
                   ring_head : id_idx;

  csfw_links #(
    .MAX_REQUESTERS(MAX_REQUESTERS)
  ) u_links (
    .clk    (clk),
    .rd_en  (req_fire),
    .rd_addr(rd_addr),
    .nx_rd  (nx_rd),
    .pv_rd  (pv_rd),
    .nx_we  (nx_we),
    .nx_wa  (nx_wa),
    .nx_wd  (nx_wd),
    .pv_we  (pv_we),
    .pv_wa  (pv_wa),
    .pv_wd  (pv_wd)
  );

  // Decide the operation from the latched request and the read links
  always_comb begin
    waits      = in_range_q && waiting_flag[idx_q];
    st_next    = csfw_pkg::ST_NOT_WAITING;
    wv_next    = 1'b0;
    count_next = sem_count;
    do_enq     = 1'b0;
    do_unl     = 1'b0;
    unl_node   = idx_q;
    unique case (req_q)
      csfw_pkg::REQ_ACQUIRE: begin
        if (waits) begin
          st_next = csfw_pkg::ST_ALREADY;
        end else if (sem_count != '0) begin
          count_next = sem_count - COUNT_BITS'(1);
          st_next    = csfw_pkg::ST_GRANTED;
        end else if (in_range_q) begin
          do_enq  = 1'b1;
          st_next = csfw_pkg::ST_QUEUED;
        end else begin
          st_next = csfw_pkg::ST_BUSY;
        end
      end
      csfw_pkg::REQ_TRY_ACQUIRE: begin
        if (sem_count != '0) begin
          count_next = sem_count - COUNT_BITS'(1);
          st_next    = csfw_pkg::ST_GRANTED;
        end else begin
          st_next = csfw_pkg::ST_BUSY;
        end
      end
      csfw_pkg::REQ_RELEASE: begin
        if (ring_nonempty) begin
          do_unl   = 1'b1;
          unl_node = ring_head;
          wv_next  = 1'b1;
          st_next  = csfw_pkg::ST_HANDED;
        end else if (&sem_count) begin
          st_next = csfw_pkg::ST_SATURATED;
        end else begin
          count_next = sem_count + COUNT_BITS'(1);
          st_next    = csfw_pkg::ST_RAISED;
        end
      end
      csfw_pkg::REQ_CANCEL: begin
        if (waits) begin
          do_unl  = 1'b1;
          st_next = csfw_pkg::ST_CANCELLED;
        end
      end
      default: begin
        st_next = waits ? csfw_pkg::ST_ALREADY : csfw_pkg::ST_NOT_WAITING;
      end
    endcase
    unl_last = (nx_rd == unl_node);
    sw_next  = in_range_q &&
               (do_enq || (waiting_flag[idx_q] && !(do_unl && unl_node == idx_q)));
  end

  // Link writes: first half in execution, second half of an enqueue after it
  always_comb begin
    nx_we = 1'b0;
    nx_wa = idx_q;
    nx_wd = idx_q;
    pv_we = 1'b0;
    pv_wa = idx_q;
    pv_wd = idx_q;
    priority if (state == csfw_pkg::S_LINK) begin
      nx_we = 1'b1;
      nx_wa = pend_tail;
      nx_wd = ring_tail;
      pv_we = 1'b1;
      pv_wa = ring_head;
      pv_wd = ring_tail;
    end else if (exec_fire && do_enq) begin
      nx_we = 1'b1;
      nx_wd = ring_nonempty ? ring_head : idx_q;
      pv_we = 1'b1;
      pv_wd = ring_nonempty ? ring_tail : idx_q;
    end else if (exec_fire && do_unl && !unl_last) begin
      nx_we = 1'b1;
      nx_wa = pv_rd;
      nx_wd = nx_rd;
      pv_we = 1'b1;
      pv_wa = nx_rd;
      pv_wd = pv_rd;
    end else begin
      nx_we = 1'b0;
    end
  end

  // Sequence one request: accept, execute, optional second link write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csfw_pkg::S_IDLE;
    end else begin
      unique case (state)
        csfw_pkg::S_IDLE: begin
          if (req_fire) begin
            state <= csfw_pkg::S_EXEC;
          end
        end
        csfw_pkg::S_EXEC: begin
          if (exec_fire) begin
            state <= (do_enq && ring_nonempty) ? csfw_pkg::S_LINK : csfw_pkg::S_IDLE;
          end
        end
        csfw_pkg::S_LINK: begin
          state <= csfw_pkg::S_IDLE;
        end
        default: begin
          state <= csfw_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Latch the request on acceptance
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q      <= csfw_pkg::req_t'(req_type);
      idx_q      <= id_idx;
      in_range_q <= id_in_range;
    end
  end

  // Update count, flags and ring ends; configuration reloads the count and empties the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= '0;
      sem_count     <= '0;
      waiting_flag  <= '0;
      ring_head     <= '0;
      ring_tail     <= '0;
      ring_nonempty <= 1'b0;
    end else if (cfg_write) begin
      initial_count <= pwdata[CNT_CFG_W-1:0];
      sem_count     <= COUNT_BITS'(pwdata[CNT_CFG_W-1:0]);
      waiting_flag  <= '0;
      ring_head     <= '0;
      ring_nonempty <= 1'b0;
    end else if (exec_fire) begin
      sem_count <= count_next;
      if (do_enq) begin
        waiting_flag[idx_q] <= 1'b1;
        ring_tail           <= idx_q;
        if (!ring_nonempty) begin
          ring_head     <= idx_q;
          ring_nonempty <= 1'b1;
        end
      end
      if (do_unl) begin
        waiting_flag[unl_node] <= 1'b0;
        if (unl_last) begin
          ring_nonempty <= 1'b0;
        end else begin
          if (ring_head == unl_node) begin
            ring_head <= nx_rd;
          end
          if (ring_tail == unl_node) begin
            ring_tail <= pv_rd;
          end
        end
      end
    end
  end

  // Hold the old tail for the second enqueue write
  always_ff @(posedge clk) begin
    if (exec_fire && do_enq) begin
      pend_tail <= ring_tail;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      status        <= st_next;
      woken_valid   <= wv_next;
      woken_id      <= wv_next ? csfw_pkg::ID_W'(ring_head) : '0;
      count_now     <= csfw_pkg::COUNT_W'(count_next);
      still_waiting <= sw_next;
    end
  end

  // A woken id comes only with a hand-over
  a_woken_handed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (woken_valid == (status == csfw_pkg::ST_HANDED)))
    else $error("woken_valid disagrees with status");

  // An empty ring has no waiting requester
  a_empty_no_waiters: assert property (@(posedge clk) disable iff (rst)
    !ring_nonempty |-> (waiting_flag == '0))
    else $error("waiting flag set with an empty ring");

  // The head of a non-empty ring is waiting
  a_head_waits: assert property (@(posedge clk) disable iff (rst)
    ring_nonempty |-> waiting_flag[ring_head])
    else $error("ring head is not waiting");

  // An accepted request goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == csfw_pkg::S_EXEC))
    else $error("accepted request did not enter execution");

endmodule
